>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that prop holds in the cycle after trig
`define ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

>>> rtl/udfu_pkg.sv
// ----------------------------------------------------------------------------
// udfu_pkg
// Types, codes and helpers of the DFU class-request state machine.
// ----------------------------------------------------------------------------
package udfu_pkg;

  localparam int unsigned PollW = 24;
  localparam int unsigned LenW  = 16;
  localparam int unsigned CfgW  = 32;

  localparam logic [CfgW-1:0] BusyPollReset     = 32'd700;
  localparam logic [CfgW-1:0] ManifestPollReset = 32'd1200;

  typedef enum logic [3:0] {
    ST_APP_IDLE = 4'd0,
    ST_DETACH   = 4'd1,
    ST_IDLE     = 4'd2,
    ST_DN_SYNC  = 4'd3,
    ST_DN_BUSY  = 4'd4,
    ST_DN_IDLE  = 4'd5,
    ST_MAN_SYNC = 4'd6,
    ST_MAN      = 4'd7,
    ST_MAN_WAIT = 4'd8,
    ST_UP_IDLE  = 4'd9,
    ST_ERROR    = 4'd10
  } dfu_state_e;

  localparam logic [3:0] SsOk       = 4'd0;
  localparam logic [3:0] SsFirmware = 4'd10;
  localparam logic [3:0] SsUnknown  = 4'd14;
  localparam logic [3:0] SsStalled  = 4'd15;

  localparam logic [1:0] ActRequest = 2'd0;
  localparam logic [1:0] ActDone    = 2'd1;
  localparam logic [1:0] ActFail    = 2'd2;

  localparam logic [7:0] RqDetach    = 8'd0;
  localparam logic [7:0] RqDnload    = 8'd1;
  localparam logic [7:0] RqUpload    = 8'd2;
  localparam logic [7:0] RqGetStatus = 8'd3;
  localparam logic [7:0] RqClrStatus = 8'd4;
  localparam logic [7:0] RqGetState  = 8'd5;
  localparam logic [7:0] RqAbort     = 8'd6;

  typedef enum logic [2:0] {
    RS_NONE   = 3'd0,
    RS_ACK    = 3'd1,
    RS_STALL  = 3'd2,
    RS_STATUS = 3'd3,
    RS_STATE  = 3'd4,
    RS_DATA   = 3'd5
  } resp_e;

  typedef enum logic [2:0] {
    EC_NONE     = 3'd0,
    EC_DN_START = 3'd1,
    EC_DN_NEXT  = 3'd2,
    EC_CHECK    = 3'd3,
    EC_UP_START = 3'd4,
    EC_UP_NEXT  = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [1:0]      action;
    logic [7:0]      code;
    logic [LenW-1:0] length;
    logic            page_waiting;
    logic            download_done;
    logic            image_dirty;
    logic [3:0]      engine_status;
  } req_t;

  typedef struct packed {
    resp_e            response;
    cmd_e             engine_command;
    logic [3:0]       reply_status;
    logic [3:0]       reply_state;
    logic [PollW-1:0] poll_delay;
    logic [LenW-1:0]  data_length;
    logic             detach_pending;
  } res_t;

  function automatic logic [PollW-1:0] sat_poll(logic [CfgW-1:0] t);
    return (|t[CfgW-1:PollW]) ? {PollW{1'b1}} : t[PollW-1:0];
  endfunction

endpackage

>>> rtl/udfu_fsm.sv
// ----------------------------------------------------------------------------
// udfu_fsm
// Transition and response logic for one DFU transaction.
// ----------------------------------------------------------------------------
module udfu_fsm (
  input  udfu_pkg::dfu_state_e   state_i,
  input  logic [3:0]             status_i,
  input  udfu_pkg::req_t         req_i,
  input  logic [31:0]            busy_poll_i,
  input  logic [31:0]            manifest_poll_i,
  output udfu_pkg::dfu_state_e   state_o,
  output logic [3:0]             status_o,
  output udfu_pkg::res_t         res_o
);

  logic known;
  logic len_nz;
  logic blocked;
  logic is_getstate;
  logic is_getstatus;

  assign known = state_i inside {udfu_pkg::ST_IDLE, udfu_pkg::ST_DN_SYNC,
                                 udfu_pkg::ST_DN_BUSY, udfu_pkg::ST_DN_IDLE,
                                 udfu_pkg::ST_MAN_SYNC, udfu_pkg::ST_MAN,
                                 udfu_pkg::ST_UP_IDLE, udfu_pkg::ST_ERROR};
  assign len_nz  = |req_i.length;
  assign blocked = state_i inside {udfu_pkg::ST_DN_BUSY, udfu_pkg::ST_MAN};
  assign is_getstate  = (req_i.code == udfu_pkg::RqGetState) && !blocked;
  assign is_getstatus = (req_i.code == udfu_pkg::RqGetStatus) && !blocked;

  // next state and status
  always_comb begin
    state_o  = state_i;
    status_o = status_i;
    case (req_i.action)
      udfu_pkg::ActDone: begin
        if (state_i == udfu_pkg::ST_DN_BUSY) begin
          state_o = udfu_pkg::ST_DN_SYNC;
        end else if (state_i == udfu_pkg::ST_MAN) begin
          state_o = udfu_pkg::ST_MAN_SYNC;
        end
      end
      udfu_pkg::ActFail: begin
        state_o  = udfu_pkg::ST_ERROR;
        status_o = udfu_pkg::SsUnknown;
      end
      udfu_pkg::ActRequest: begin
        if (!known || is_getstate) begin
          state_o = state_i;
        end else if (is_getstatus) begin
          if (state_i == udfu_pkg::ST_DN_SYNC) begin
            status_o = udfu_pkg::SsOk;
            state_o  = req_i.page_waiting ? udfu_pkg::ST_DN_BUSY : udfu_pkg::ST_DN_IDLE;
          end else if (state_i == udfu_pkg::ST_MAN_SYNC) begin
            status_o = udfu_pkg::SsOk;
            state_o  = req_i.download_done ? udfu_pkg::ST_IDLE : udfu_pkg::ST_MAN;
          end
        end else begin
          state_o  = udfu_pkg::ST_ERROR;
          status_o = udfu_pkg::SsStalled;
          case (state_i)
            udfu_pkg::ST_IDLE: begin
              if (req_i.code == udfu_pkg::RqDnload && len_nz) begin
                state_o  = udfu_pkg::ST_DN_SYNC;
                status_o = udfu_pkg::SsOk;
              end else if (req_i.code == udfu_pkg::RqUpload && len_nz) begin
                if (req_i.engine_status == udfu_pkg::SsOk) begin
                  state_o  = udfu_pkg::ST_UP_IDLE;
                  status_o = udfu_pkg::SsOk;
                end else begin
                  status_o = req_i.engine_status;
                end
              end else if (req_i.code == udfu_pkg::RqAbort) begin
                state_o  = state_i;
                status_o = status_i;
              end else if (req_i.code == udfu_pkg::RqDetach) begin
                if (req_i.image_dirty) begin
                  status_o = udfu_pkg::SsFirmware;
                end else begin
                  state_o  = udfu_pkg::ST_DETACH;
                  status_o = udfu_pkg::SsOk;
                end
              end
            end
            udfu_pkg::ST_DN_IDLE: begin
              if (req_i.code == udfu_pkg::RqDnload && len_nz) begin
                state_o  = udfu_pkg::ST_DN_SYNC;
                status_o = udfu_pkg::SsOk;
              end else if (req_i.code == udfu_pkg::RqDnload) begin
                if (req_i.engine_status == udfu_pkg::SsOk) begin
                  state_o  = udfu_pkg::ST_MAN_SYNC;
                  status_o = udfu_pkg::SsOk;
                end else begin
                  status_o = req_i.engine_status;
                end
              end else if (req_i.code == udfu_pkg::RqAbort) begin
                state_o  = udfu_pkg::ST_IDLE;
                status_o = udfu_pkg::SsOk;
              end
            end
            udfu_pkg::ST_UP_IDLE: begin
              if (req_i.code == udfu_pkg::RqUpload) begin
                state_o  = state_i;
                status_o = status_i;
                if (len_nz) begin
                  if (req_i.engine_status == udfu_pkg::SsOk) begin
                    status_o = udfu_pkg::SsOk;
                  end else begin
                    state_o  = udfu_pkg::ST_ERROR;
                    status_o = req_i.engine_status;
                  end
                end
              end else if (req_i.code == udfu_pkg::RqAbort) begin
                state_o  = udfu_pkg::ST_IDLE;
                status_o = udfu_pkg::SsOk;
              end
            end
            udfu_pkg::ST_ERROR: begin
              if (req_i.code == udfu_pkg::RqClrStatus) begin
                state_o  = udfu_pkg::ST_IDLE;
                status_o = udfu_pkg::SsOk;
              end
            end
            default: begin
              state_o  = udfu_pkg::ST_ERROR;
              status_o = udfu_pkg::SsStalled;
            end
          endcase
        end
      end
      default: begin
        state_o  = state_i;
        status_o = status_i;
      end
    endcase
  end

  // response, engine command and reply fields
  always_comb begin
    res_o = '0;
    res_o.response       = udfu_pkg::RS_NONE;
    res_o.engine_command = udfu_pkg::EC_NONE;
    case (req_i.action)
      udfu_pkg::ActFail: begin
        res_o.response = udfu_pkg::RS_STALL;
      end
      udfu_pkg::ActRequest: begin
        if (!known) begin
          res_o.response = udfu_pkg::RS_STALL;
        end else if (is_getstate) begin
          res_o.response = udfu_pkg::RS_STATE;
        end else if (is_getstatus) begin
          res_o.response = udfu_pkg::RS_STATUS;
          if (state_i == udfu_pkg::ST_DN_SYNC && req_i.page_waiting) begin
            res_o.poll_delay = udfu_pkg::sat_poll(busy_poll_i);
          end else if (state_i == udfu_pkg::ST_MAN_SYNC && !req_i.download_done) begin
            res_o.poll_delay = udfu_pkg::sat_poll(manifest_poll_i);
          end
        end else begin
          res_o.response = udfu_pkg::RS_STALL;
          case (state_i)
            udfu_pkg::ST_IDLE: begin
              if (req_i.code == udfu_pkg::RqDnload && len_nz) begin
                res_o.response       = udfu_pkg::RS_DATA;
                res_o.engine_command = udfu_pkg::EC_DN_START;
                res_o.data_length    = req_i.length;
              end else if (req_i.code == udfu_pkg::RqUpload && len_nz) begin
                res_o.engine_command = udfu_pkg::EC_UP_START;
                res_o.response = (req_i.engine_status == udfu_pkg::SsOk) ?
                                 udfu_pkg::RS_NONE : udfu_pkg::RS_STALL;
              end else if (req_i.code == udfu_pkg::RqAbort) begin
                res_o.response = udfu_pkg::RS_ACK;
              end else if (req_i.code == udfu_pkg::RqDetach) begin
                res_o.response = req_i.image_dirty ? udfu_pkg::RS_STALL : udfu_pkg::RS_ACK;
              end
            end
            udfu_pkg::ST_DN_IDLE: begin
              if (req_i.code == udfu_pkg::RqDnload && len_nz) begin
                res_o.response       = udfu_pkg::RS_DATA;
                res_o.engine_command = udfu_pkg::EC_DN_NEXT;
                res_o.data_length    = req_i.length;
              end else if (req_i.code == udfu_pkg::RqDnload) begin
                res_o.response       = udfu_pkg::RS_ACK;
                res_o.engine_command = udfu_pkg::EC_CHECK;
              end else if (req_i.code == udfu_pkg::RqAbort) begin
                res_o.response = udfu_pkg::RS_ACK;
              end
            end
            udfu_pkg::ST_UP_IDLE: begin
              if (req_i.code == udfu_pkg::RqUpload) begin
                res_o.response = udfu_pkg::RS_NONE;
                if (len_nz) begin
                  res_o.engine_command = udfu_pkg::EC_UP_NEXT;
                  if (req_i.engine_status != udfu_pkg::SsOk) begin
                    res_o.response = udfu_pkg::RS_STALL;
                  end
                end
              end else if (req_i.code == udfu_pkg::RqAbort) begin
                res_o.response = udfu_pkg::RS_ACK;
              end
            end
            udfu_pkg::ST_ERROR: begin
              if (req_i.code == udfu_pkg::RqClrStatus) begin
                res_o.response = udfu_pkg::RS_ACK;
              end
            end
            default: begin
              res_o.response = udfu_pkg::RS_STALL;
            end
          endcase
        end
      end
      default: begin
        res_o.response = udfu_pkg::RS_NONE;
      end
    endcase
    if (res_o.response == udfu_pkg::RS_STATUS) begin
      res_o.reply_status = status_o;
    end
    if (res_o.response == udfu_pkg::RS_STATUS || res_o.response == udfu_pkg::RS_STATE) begin
      res_o.reply_state = state_o;
    end
    res_o.detach_pending = (state_o == udfu_pkg::ST_DETACH);
  end

endmodule

>>> rtl/usb_dfu_request_state_machine_unit.sv
// ----------------------------------------------------------------------------
// usb_dfu_request_state_machine_unit
// Device-side DFU 1.1 class-request state machine with poll-time registers.
// ----------------------------------------------------------------------------
// The state transition and the whole result of a transaction are computed
// from the input ports and the DFU state register and land in the result
// register at the accepting edge. A new transaction is accepted every
// cycle while the result register is empty or being drained, so the
// sustained rate is one transaction per clock.
// Poll-time registers sit at byte addresses 0 and 4 on the APB port.
module usb_dfu_request_state_machine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  request_code_i,
  input  logic [15:0] request_length_i,
  input  logic        page_waiting_i,
  input  logic        download_done_i,
  input  logic        image_dirty_i,
  input  logic [3:0]  engine_status_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  response_o,
  output logic [2:0]  engine_command_o,
  output logic [3:0]  reply_status_o,
  output logic [3:0]  reply_state_o,
  output logic [23:0] poll_delay_o,
  output logic [15:0] data_length_o,
  output logic        detach_pending_o
);

  `include "assert_macros.svh"

  logic [31:0]          busy_poll_q;
  logic [31:0]          manifest_poll_q;
  udfu_pkg::dfu_state_e state_q, state_d;
  logic [3:0]           status_q, status_d;
  udfu_pkg::req_t       req;
  udfu_pkg::res_t       res_d, res_q;
  logic                 out_valid_q;
  logic                 in_fire;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? manifest_poll_q : busy_poll_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_poll_q     <= udfu_pkg::BusyPollReset;
      manifest_poll_q <= udfu_pkg::ManifestPollReset;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        manifest_poll_q <= pwdata;
      end else begin
        busy_poll_q <= pwdata;
      end
    end
  end

  assign req.action        = action_i;
  assign req.code          = request_code_i;
  assign req.length        = request_length_i;
  assign req.page_waiting  = page_waiting_i;
  assign req.download_done = download_done_i;
  assign req.image_dirty   = image_dirty_i;
  assign req.engine_status = engine_status_i;

  udfu_fsm u_fsm (
    .state_i         (state_q),
    .status_i        (status_q),
    .req_i           (req),
    .busy_poll_i     (busy_poll_q),
    .manifest_poll_i (manifest_poll_q),
    .state_o         (state_d),
    .status_o        (status_d),
    .res_o           (res_d)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= udfu_pkg::ST_IDLE;
      status_q    <= udfu_pkg::SsOk;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q     <= state_d;
        status_q    <= status_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign response_o       = res_q.response;
  assign engine_command_o = res_q.engine_command;
  assign reply_status_o   = res_q.reply_status;
  assign reply_state_o    = res_q.reply_state;
  assign poll_delay_o     = res_q.poll_delay;
  assign data_length_o    = res_q.data_length;
  assign detach_pending_o = res_q.detach_pending;

  `ASSERT_CLK(a_no_app_state,
              state_q != udfu_pkg::ST_APP_IDLE && state_q != udfu_pkg::ST_MAN_WAIT,
              "unreachable DFU state entered")
  `ASSERT_CLK(a_detach_match,
              !out_valid_q || (detach_pending_o == (state_q == udfu_pkg::ST_DETACH)),
              "detach flag disagrees with state")
  `ASSERT_NEXT(a_fail_error, in_fire && action_i == udfu_pkg::ActFail,
               state_q == udfu_pkg::ST_ERROR && status_q == udfu_pkg::SsUnknown,
               "failed reply did not enter error")
  `ASSERT_CLK(a_poll_state,
              !out_valid_q || poll_delay_o == '0 || state_q == udfu_pkg::ST_DN_BUSY ||
              state_q == udfu_pkg::ST_MAN,
              "poll timeout outside busy or manifest")

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the DFU class-request state machine against its own predictor.
// A short table of directed transactions walks the download, manifest,
// upload, detach and error paths, then seven register settings each run a
// random phase biased toward legal request sequences. The handshakes idle
// at random (in some phases only one of them does), and every result is compared field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  import udfu_pkg::*;

  localparam logic [2:0] BusyPollAddr     = 3'd0;
  localparam logic [2:0] ManifestPollAddr = 3'd4;
  localparam logic [1:0] ActIgnored       = 2'd3;
  localparam logic [7:0] RqUnknown        = 8'hFF;
  localparam int unsigned PhaseCount      = 7;
  localparam int unsigned PhaseItems      = 100;

  typedef struct {
    req_t rq;
    bit   typed;
    res_t res;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  action_i;
  logic [7:0]  request_code_i;
  logic [15:0] request_length_i;
  logic        page_waiting_i;
  logic        download_done_i;
  logic        image_dirty_i;
  logic [3:0]  engine_status_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  response_o;
  logic [2:0]  engine_command_o;
  logic [3:0]  reply_status_o;
  logic [3:0]  reply_state_o;
  logic [23:0] poll_delay_o;
  logic [15:0] data_length_o;
  logic        detach_pending_o;

  dfu_state_e  cur_state;
  logic [3:0]  cur_status;
  logic [31:0] busy_poll;
  logic [31:0] manifest_poll;
  res_t        expected_q[$];
  stim_row_t   directed_rows[$];
  int unsigned fail_cnt;
  bit          tx_idle;
  bit          rx_idle;

  usb_dfu_request_state_machine_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .request_code_i   (request_code_i),
    .request_length_i (request_length_i),
    .page_waiting_i   (page_waiting_i),
    .download_done_i  (download_done_i),
    .image_dirty_i    (image_dirty_i),
    .engine_status_i  (engine_status_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .response_o       (response_o),
    .engine_command_o (engine_command_o),
    .reply_status_o   (reply_status_o),
    .reply_state_o    (reply_state_o),
    .poll_delay_o     (poll_delay_o),
    .data_length_o    (data_length_o),
    .detach_pending_o (detach_pending_o)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic req_t mk_request(logic [1:0] act, logic [7:0] code, logic [15:0] len,
                                      logic page, logic done, logic dirty, logic [3:0] est);
    req_t rq;
    rq.action        = act;
    rq.code          = code;
    rq.length        = len;
    rq.page_waiting  = page;
    rq.download_done = done;
    rq.image_dirty   = dirty;
    rq.engine_status = est;
    return rq;
  endfunction

  function automatic res_t mk_result(resp_e rsp, cmd_e cmd, logic [3:0] ss, logic [3:0] st,
                                     logic [23:0] pt, logic [15:0] dl, logic dp);
    res_t r;
    r.response       = rsp;
    r.engine_command = cmd;
    r.reply_status   = ss;
    r.reply_state    = st;
    r.poll_delay     = pt;
    r.data_length    = dl;
    r.detach_pending = dp;
    return r;
  endfunction

  function automatic logic [23:0] clamp_poll(logic [31:0] t);
    return (t[31:24] != 8'd0) ? 24'hFF_FFFF : t[23:0];
  endfunction

  // Advance the predicted DFU state by one transaction and return its result.
  function automatic res_t dfu_predict(req_t rq);
    res_t       r;
    dfu_state_e st;
    logic       known;
    logic       bad;
    r = '0;
    r.response = RS_NONE;
    r.engine_command = EC_NONE;
    st = cur_state;
    known = (st >= ST_IDLE) && (st <= ST_ERROR) && (st != ST_MAN_WAIT);
    bad = 1'b0;
    case (rq.action)
      ActDone: begin
        if (st == ST_DN_BUSY) cur_state = ST_DN_SYNC;
        else if (st == ST_MAN) cur_state = ST_MAN_SYNC;
      end
      ActFail: begin
        cur_state = ST_ERROR;
        cur_status = SsUnknown;
        r.response = RS_STALL;
      end
      ActRequest: begin
        if (!known) begin
          r.response = RS_STALL;
        end else if (rq.code == RqGetState && st != ST_DN_BUSY && st != ST_MAN) begin
          r.response = RS_STATE;
        end else if (rq.code == RqGetStatus && st != ST_DN_BUSY && st != ST_MAN) begin
          r.response = RS_STATUS;
          if (st == ST_DN_SYNC) begin
            cur_status = SsOk;
            if (rq.page_waiting) begin
              cur_state = ST_DN_BUSY;
              r.poll_delay = clamp_poll(busy_poll);
            end else begin
              cur_state = ST_DN_IDLE;
            end
          end else if (st == ST_MAN_SYNC) begin
            cur_status = SsOk;
            if (!rq.download_done) begin
              cur_state = ST_MAN;
              r.poll_delay = clamp_poll(manifest_poll);
            end else begin
              cur_state = ST_IDLE;
            end
          end
        end else if (st == ST_IDLE) begin
          if (rq.code == RqDnload && rq.length != 16'd0) begin
            r.engine_command = EC_DN_START;
            cur_state = ST_DN_SYNC;
            cur_status = SsOk;
            r.response = RS_DATA;
            r.data_length = rq.length;
          end else if (rq.code == RqUpload && rq.length != 16'd0) begin
            r.engine_command = EC_UP_START;
            if (rq.engine_status == SsOk) begin
              cur_state = ST_UP_IDLE;
              cur_status = SsOk;
            end else begin
              cur_state = ST_ERROR;
              cur_status = rq.engine_status;
              r.response = RS_STALL;
            end
          end else if (rq.code == RqAbort) begin
            r.response = RS_ACK;
          end else if (rq.code == RqDetach) begin
            if (rq.image_dirty) begin
              cur_state = ST_ERROR;
              cur_status = SsFirmware;
              r.response = RS_STALL;
            end else begin
              cur_state = ST_DETACH;
              cur_status = SsOk;
              r.response = RS_ACK;
            end
          end else begin
            bad = 1'b1;
          end
        end else if (st == ST_DN_IDLE) begin
          if (rq.code == RqDnload && rq.length != 16'd0) begin
            r.engine_command = EC_DN_NEXT;
            cur_state = ST_DN_SYNC;
            cur_status = SsOk;
            r.response = RS_DATA;
            r.data_length = rq.length;
          end else if (rq.code == RqDnload) begin
            r.engine_command = EC_CHECK;
            if (rq.engine_status == SsOk) begin
              cur_state = ST_MAN_SYNC;
              cur_status = SsOk;
            end else begin
              cur_state = ST_ERROR;
              cur_status = rq.engine_status;
            end
            r.response = RS_ACK;
          end else if (rq.code == RqAbort) begin
            cur_state = ST_IDLE;
            cur_status = SsOk;
            r.response = RS_ACK;
          end else begin
            bad = 1'b1;
          end
        end else if (st == ST_UP_IDLE) begin
          if (rq.code == RqUpload) begin
            if (rq.length != 16'd0) begin
              r.engine_command = EC_UP_NEXT;
              if (rq.engine_status == SsOk) begin
                cur_status = SsOk;
              end else begin
                cur_state = ST_ERROR;
                cur_status = rq.engine_status;
                r.response = RS_STALL;
              end
            end
          end else if (rq.code == RqAbort) begin
            cur_state = ST_IDLE;
            cur_status = SsOk;
            r.response = RS_ACK;
          end else begin
            bad = 1'b1;
          end
        end else if (st == ST_ERROR && rq.code == RqClrStatus) begin
          cur_state = ST_IDLE;
          cur_status = SsOk;
          r.response = RS_ACK;
        end else begin
          bad = 1'b1;
        end
        if (bad) begin
          cur_state = ST_ERROR;
          cur_status = SsStalled;
          r.response = RS_STALL;
        end
      end
      default: ;
    endcase
    r.reply_status = (r.response == RS_STATUS) ? cur_status : 4'd0;
    r.reply_state = (r.response == RS_STATUS || r.response == RS_STATE) ? cur_state : 4'd0;
    r.detach_pending = (cur_state == ST_DETACH);
    return r;
  endfunction

  function automatic logic [15:0] pick_length();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 16'd0;
    if (sel == 1) return 16'hFFFF;
    return 16'($urandom_range(1, 65535));
  endfunction

  function automatic logic [15:0] pick_nonzero_length();
    return ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535));
  endfunction

  function automatic logic [3:0] pick_engine_status();
    return ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15)) : SsOk;
  endfunction

  // Mostly a request that fits the predicted state, with random content.
  function automatic req_t gen_request();
    req_t        rq;
    int unsigned sel;
    rq.action        = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : ActRequest;
    rq.code          = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7))
                                                   : 8'($urandom_range(0, 255));
    rq.length        = pick_length();
    rq.page_waiting  = 1'($urandom);
    rq.download_done = 1'($urandom);
    rq.image_dirty   = 1'($urandom);
    rq.engine_status = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 9) < 2) return rq;
    rq.action = ActRequest;
    sel = $urandom_range(0, 9);
    case (cur_state)
      ST_IDLE: begin
        if (sel < 4) begin
          rq.code = RqDnload;
          rq.length = pick_nonzero_length();
        end else if (sel < 6) begin
          rq.code = RqUpload;
          rq.length = pick_nonzero_length();
          rq.engine_status = pick_engine_status();
        end else if (sel == 6) begin
          rq.code = RqAbort;
        end else if (sel == 7) begin
          rq.code = RqDetach;
        end else begin
          rq.code = (sel == 8) ? RqGetStatus : RqGetState;
        end
      end
      ST_DN_SYNC, ST_MAN_SYNC: rq.code = RqGetStatus;
      ST_DN_BUSY, ST_MAN: begin
        if (sel < 8) rq.action = ActDone;
        else rq.code = RqGetStatus;
      end
      ST_DN_IDLE: begin
        if (sel < 5) begin
          rq.code = RqDnload;
          rq.length = pick_nonzero_length();
        end else if (sel < 7) begin
          rq.code = RqDnload;
          rq.length = 16'd0;
          rq.engine_status = pick_engine_status();
        end else if (sel == 7) begin
          rq.code = RqAbort;
        end else begin
          rq.code = (sel == 8) ? RqGetStatus : RqGetState;
        end
      end
      ST_UP_IDLE: begin
        if (sel < 7) begin
          rq.code = RqUpload;
          rq.engine_status = pick_engine_status();
        end else begin
          rq.code = (sel == 7) ? RqAbort : RqGetStatus;
        end
      end
      ST_ERROR: rq.code = (sel < 7) ? RqClrStatus : RqGetStatus;
      default: begin
        if (sel < 5) rq.action = ActFail;
      end
    endcase
    return rq;
  endfunction

  task automatic send_request(req_t rq, bit typed, res_t fixed);
    int unsigned gap;
    res_t        predicted;
    gap = tx_idle ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    action_i         <= rq.action;
    request_code_i   <= rq.code;
    request_length_i <= rq.length;
    page_waiting_i   <= rq.page_waiting;
    download_done_i  <= rq.download_done;
    image_dirty_i    <= rq.image_dirty;
    engine_status_i  <= rq.engine_status;
    in_valid_i       <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = dfu_predict(rq);
    expected_q.push_back(typed ? fixed : predicted);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == BusyPollAddr) busy_poll = data;
    else manifest_poll = data;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("result with no transaction outstanding");
        fail_cnt++;
      end else begin
        want = expected_q.pop_front();
        check_field("response", 32'(want.response), 32'(response_o));
        check_field("engine_command", 32'(want.engine_command), 32'(engine_command_o));
        check_field("reply_status", 32'(want.reply_status), 32'(reply_status_o));
        check_field("reply_state", 32'(want.reply_state), 32'(reply_state_o));
        check_field("poll_delay", 32'(want.poll_delay), 32'(poll_delay_o));
        check_field("data_length", 32'(want.data_length), 32'(data_length_o));
        check_field("detach_pending", 32'(want.detach_pending), 32'(detach_pending_o));
      end
    end
  end

  initial begin : result_sink
    int unsigned stall;
    out_ready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = rx_idle ? $urandom_range(0, 16) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    #10_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] busy_val;
    logic [31:0] manifest_val;
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_valid_i       <= 1'b0;
    action_i         <= ActRequest;
    request_code_i   <= RqGetState;
    request_length_i <= '0;
    page_waiting_i   <= 1'b0;
    download_done_i  <= 1'b0;
    image_dirty_i    <= 1'b0;
    engine_status_i  <= SsOk;
    fail_cnt      = 0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    cur_state     = ST_IDLE;
    cur_status    = SsOk;
    busy_poll     = BusyPollReset;
    manifest_poll = ManifestPollReset;

    directed_rows.push_back('{mk_request(ActRequest, RqGetState, 16'd0, 1'b0, 1'b0, 1'b0, SsOk),
                              1'b1,
                              mk_result(RS_STATE, EC_NONE, SsOk, ST_IDLE, 24'd0, 16'd0, 1'b0)});
    directed_rows.push_back('{mk_request(ActRequest, RqGetStatus, 16'd0, 1'b0, 1'b0, 1'b0,
                                         SsOk), 1'b1,
                              mk_result(RS_STATUS, EC_NONE, SsOk, ST_IDLE, 24'd0, 16'd0, 1'b0)});
    directed_rows.push_back('{mk_request(ActRequest, RqDnload, 16'hFFFF, 1'b0, 1'b0, 1'b0, SsOk),
                              1'b1,
                              mk_result(RS_DATA, EC_DN_START, 4'd0, 4'd0, 24'd0, 16'hFFFF,
                                        1'b0)});
    directed_rows.push_back('{mk_request(ActRequest, RqGetStatus, 16'd0, 1'b1, 1'b0, 1'b0,
                                         SsOk), 1'b1,
                              mk_result(RS_STATUS, EC_NONE, SsOk, ST_DN_BUSY, 24'd700, 16'd0,
                                        1'b0)});
    directed_rows.push_back('{mk_request(ActRequest, RqGetStatus, 16'd0, 1'b0, 1'b0, 1'b0,
                                         SsOk), 1'b1,
                              mk_result(RS_STALL, EC_NONE, 4'd0, 4'd0, 24'd0, 16'd0, 1'b0)});
    directed_rows.push_back('{mk_request(ActRequest, RqClrStatus, 16'd0, 1'b0, 1'b0, 1'b0,
                                         SsOk), 1'b0, '0});
    directed_rows.push_back('{mk_request(ActRequest, RqDnload, 16'd1, 1'b0, 1'b0, 1'b0, SsOk),
                              1'b0, '0});
    directed_rows.push_back('{mk_request(ActRequest, RqGetStatus, 16'd0, 1'b0, 1'b0, 1'b0,
                                         SsOk), 1'b0, '0});
    directed_rows.push_back('{mk_request(ActDone, RqDetach, 16'd0, 1'b0, 1'b0, 1'b0, SsOk),
                              1'b0, '0});
    directed_rows.push_back('{mk_request(ActRequest, RqDnload, 16'd0, 1'b0, 1'b0, 1'b0, SsOk),
                              1'b0, '0});
    directed_rows.push_back('{mk_request(ActRequest, RqGetStatus, 16'd0, 1'b0, 1'b0, 1'b0,
                                         SsOk), 1'b1,
                              mk_result(RS_STATUS, EC_NONE, SsOk, ST_MAN, 24'd1200, 16'd0,
                                        1'b0)});
    directed_rows.push_back('{mk_request(ActDone, RqDetach, 16'd0, 1'b0, 1'b0, 1'b0, SsOk),
                              1'b0, '0});
    directed_rows.push_back('{mk_request(ActRequest, RqGetStatus, 16'd0, 1'b0, 1'b1, 1'b0,
                                         SsOk), 1'b0, '0});
    directed_rows.push_back('{mk_request(ActRequest, RqUpload, 16'd16, 1'b0, 1'b0, 1'b0, SsOk),
                              1'b0, '0});
    directed_rows.push_back('{mk_request(ActRequest, RqUpload, 16'd0, 1'b0, 1'b0, 1'b0, SsOk),
                              1'b0, '0});
    directed_rows.push_back('{mk_request(ActRequest, RqUpload, 16'hFFFF, 1'b0, 1'b0, 1'b0, 4'hF),
                              1'b1,
                              mk_result(RS_STALL, EC_UP_NEXT, 4'd0, 4'd0, 24'd0, 16'd0, 1'b0)});
    directed_rows.push_back('{mk_request(ActRequest, RqClrStatus, 16'd0, 1'b0, 1'b0, 1'b0,
                                         SsOk), 1'b0, '0});
    directed_rows.push_back('{mk_request(ActRequest, RqDetach, 16'd0, 1'b0, 1'b0, 1'b1, SsOk),
                              1'b1,
                              mk_result(RS_STALL, EC_NONE, 4'd0, 4'd0, 24'd0, 16'd0, 1'b0)});
    directed_rows.push_back('{mk_request(ActRequest, RqGetStatus, 16'd0, 1'b0, 1'b0, 1'b0,
                                         SsOk), 1'b1,
                              mk_result(RS_STATUS, EC_NONE, SsFirmware, ST_ERROR, 24'd0, 16'd0,
                                        1'b0)});
    directed_rows.push_back('{mk_request(ActRequest, RqClrStatus, 16'd0, 1'b0, 1'b0, 1'b0,
                                         SsOk), 1'b0, '0});
    directed_rows.push_back('{mk_request(ActRequest, RqDetach, 16'd0, 1'b0, 1'b0, 1'b0, SsOk),
                              1'b1,
                              mk_result(RS_ACK, EC_NONE, 4'd0, 4'd0, 24'd0, 16'd0, 1'b1)});
    directed_rows.push_back('{mk_request(ActRequest, RqGetState, 16'd0, 1'b0, 1'b0, 1'b0, SsOk),
                              1'b1,
                              mk_result(RS_STALL, EC_NONE, 4'd0, 4'd0, 24'd0, 16'd0, 1'b1)});
    directed_rows.push_back('{mk_request(ActIgnored, RqUnknown, 16'hFFFF, 1'b1, 1'b1, 1'b1,
                                         4'hF), 1'b0, '0});
    directed_rows.push_back('{mk_request(ActFail, RqDetach, 16'd0, 1'b0, 1'b0, 1'b0, SsOk),
                              1'b1,
                              mk_result(RS_STALL, EC_NONE, 4'd0, 4'd0, 24'd0, 16'd0, 1'b0)});
    directed_rows.push_back('{mk_request(ActRequest, RqUnknown, 16'd0, 1'b0, 1'b0, 1'b0, SsOk),
                              1'b1,
                              mk_result(RS_STALL, EC_NONE, 4'd0, 4'd0, 24'd0, 16'd0, 1'b0)});
    directed_rows.push_back('{mk_request(ActRequest, RqGetStatus, 16'd0, 1'b0, 1'b0, 1'b0,
                                         SsOk), 1'b1,
                              mk_result(RS_STATUS, EC_NONE, SsStalled, ST_ERROR, 24'd0, 16'd0,
                                        1'b0)});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].res);
    end
    in_valid_i <= 1'b0;

    for (int unsigned p = 0; p < PhaseCount; p++) begin
      // hold off until the block is idle before touching the poll registers
      wait_drained();
      case (p)
        0: begin
          busy_val = 32'd0;
          manifest_val = 32'd0;
        end
        1: begin
          busy_val = 32'hFFFF_FFFF;
          manifest_val = 32'hFFFF_FFFF;
        end
        2: begin
          busy_val = 32'h00FF_FFFF;
          manifest_val = 32'h0100_0000;
        end
        3: begin
          busy_val = 32'h0100_0000;
          manifest_val = 32'h00FF_FFFF;
        end
        default: begin
          busy_val = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 24'hFF_FFFF);
          manifest_val = ($urandom_range(0, 1) == 0) ? $urandom
                                                     : $urandom_range(0, 24'hFF_FFFF);
        end
      endcase
      apb_write(BusyPollAddr, busy_val);
      apb_write(ManifestPollAddr, manifest_val);
      tx_idle = (p % 3) != 1;
      rx_idle = (p % 3) != 2;
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        send_request(gen_request(), 1'b0, '0);
      end
      in_valid_i <= 1'b0;
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

>>> usb_dfu_request_state_machine_unit.f
+incdir+rtl
rtl/udfu_pkg.sv
rtl/udfu_fsm.sv
rtl/usb_dfu_request_state_machine_unit.sv
dv/testbench.sv
